FILE: rtl/chs_pkg.sv
// Shared types and codes for the chained hash set engine.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package chs_pkg;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 5;

  localparam int BUCKETS_DEF = 16;
  localparam int NODES_DEF   = 20;

  // Operation codes. The unused code is answered as a lookup.
  localparam logic [FUNC_W-1:0] F_LOOKUP = 2'd0;
  localparam logic [FUNC_W-1:0] F_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] F_DELETE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] R_ABSENT   = 3'd0;
  localparam logic [STATUS_W-1:0] R_PRESENT  = 3'd1;
  localparam logic [STATUS_W-1:0] R_INSERTED = 3'd2;
  localparam logic [STATUS_W-1:0] R_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] R_DELETED  = 3'd4;
  localparam logic [STATUS_W-1:0] R_NOTFOUND = 3'd5;

  // Per-node status.
  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_USED    = 2'd1;
  localparam logic [1:0] ST_DELETED = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } out_t;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_NEXT,
    RD_FREE
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_HEAD_INS,
    WR_HEAD_DEL,
    WR_SPARE_INS,
    WR_HEAD_LINK,
    WR_PREV_UNLINK,
    WR_CUR_FREE
  } wr_sel_t;

  typedef enum logic [1:0] {
    SLOT_NONE,
    SLOT_CUR,
    SLOT_HEAD
  } slot_sel_t;

  typedef struct packed {
    logic                in_take;
    logic                rd_en;
    rd_sel_t             rd_sel;
    wr_sel_t             wr_sel;
    logic                cap_head;
    logic                steps_clr;
    logic                steps_inc;
    logic                prev_load;
    logic                free_pop;
    logic                free_push;
    logic                res_load;
    logic [STATUS_W-1:0] res_code;
    slot_sel_t           res_slot;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              mod_done;
    logic              head_ok;
    logic              key_hit;
    logic              rd_empty;
    logic              next_ok;
    logic              steps_last;
    logic              free_ok;
    logic              head_used;
    logic              out_free;
    logic              clr_last;
  } sts_t;

endpackage

FILE: rtl/chs_dp.sv
// Datapath of the chained hash set engine: node memories, bucket hash,
// walk registers, free list head and result register. Depends on chs_pkg.
`timescale 1ns / 1ps

module chs_dp #(
  parameter int BUCKETS = chs_pkg::BUCKETS_DEF,
  parameter int NODES   = chs_pkg::NODES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  chs_pkg::in_t req,
  input  chs_pkg::cmd_t cmd,
  output chs_pkg::sts_t sts,
  output chs_pkg::out_t rsp,
  output logic         rsp_valid,
  input  logic         rsp_stall
);

  localparam int IDX_W = $clog2(NODES + 1);
  localparam int AW    = $clog2(NODES);
  localparam int BW    = $clog2(BUCKETS);
  localparam int SW    = $clog2(NODES);
  localparam logic [IDX_W-1:0] NIL       = IDX_W'(NODES);
  localparam logic [IDX_W-1:0] FREE_INIT = (BUCKETS < NODES) ? IDX_W'(BUCKETS) : NIL;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NODES - 1);
  localparam logic [SW-1:0]    LAST_STEP = SW'(NODES - 1);

  logic [chs_pkg::FUNC_W-1:0]   op_func;
  logic [chs_pkg::KEY_W-1:0]    op_key;
  logic [BW-1:0]                head_mod;
  logic                         mod_done;
  logic [31:0]                  head_wide;
  logic [IDX_W-1:0]             head_idx;

  logic [chs_pkg::KEY_W-1:0]    mem_key   [NODES];
  logic [1:0]                   mem_state [NODES];
  logic [IDX_W-1:0]             mem_next  [NODES];

  logic [IDX_W-1:0]             cur;
  logic [chs_pkg::KEY_W-1:0]    rd_key;
  logic [1:0]                   rd_state;
  logic [IDX_W-1:0]             rd_next;
  logic [IDX_W-1:0]             rd_addr;

  logic                         key_we;
  logic                         state_we;
  logic                         next_we;
  logic [IDX_W-1:0]             wr_addr;
  logic [1:0]                   wr_state;
  logic [IDX_W-1:0]             wr_next;

  logic [IDX_W-1:0]             clr_idx;
  logic [31:0]                  clr_wide;
  logic [31:0]                  clr_plus;
  logic [IDX_W-1:0]             clr_init;

  logic [IDX_W-1:0]             prev;
  logic [SW-1:0]                steps;
  logic [1:0]                   head_state;
  logic [IDX_W-1:0]             head_next;
  logic [IDX_W-1:0]             free_head;
  logic [chs_pkg::STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]             res_slot;
  logic [31:0]                  slot_wide;

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      op_func <= req.func;
      op_key  <= req.key;
    end
  end

  // Bucket index: a mask for a power-of-two bucket count, otherwise a
  // multiplication by the rounded-up reciprocal, with the product and then
  // the remainder registered. The quotient is exact for every 31-bit key,
  // and the remainder follows from one constant multiply and a subtract.
  generate
    if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_pow2
      assign head_mod = op_key[BW-1:0];
      assign mod_done = 1'b1;
    end else begin : g_rem
      localparam int KW = chs_pkg::KEY_W;
      localparam int SH = KW + BW;
      localparam longint unsigned RECIP =
        ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
      localparam logic [31:0] RECIP_C = 32'(RECIP);

      logic [62:0]   prod;
      logic [KW-1:0] quo;
      logic [KW-1:0] rem_full;
      logic [BW-1:0] rem;
      logic [1:0]    mod_cnt;

      assign quo      = KW'(prod >> SH);
      assign rem_full = op_key - KW'(quo * KW'(BUCKETS));

      always_ff @(posedge clk) begin
        if (rst) begin
          mod_cnt <= '0;
        end else if (cmd.in_take) begin
          mod_cnt <= 2'd2;
        end else if (mod_cnt == 2'd2) begin
          mod_cnt <= 2'd1;
          prod    <= 63'(op_key) * 63'(RECIP_C);
        end else if (mod_cnt == 2'd1) begin
          mod_cnt <= 2'd0;
          rem     <= rem_full[BW-1:0];
        end
      end

      assign head_mod = rem;
      assign mod_done = (mod_cnt == '0);
    end
  endgenerate

  assign head_wide = 32'(head_mod);
  assign head_idx  = head_wide[IDX_W-1:0];

  always_comb begin
    unique case (cmd.rd_sel)
      chs_pkg::RD_HEAD: rd_addr = head_idx;
      chs_pkg::RD_NEXT: rd_addr = rd_next;
      chs_pkg::RD_FREE: rd_addr = free_head;
      default:          rd_addr = head_idx;
    endcase
  end

  assign clr_wide = 32'(clr_idx);
  assign clr_plus = clr_wide + 32'd1;
  assign clr_init = (clr_wide < 32'(BUCKETS)) ? NIL : clr_plus[IDX_W-1:0];

  always_comb begin
    key_we   = 1'b0;
    state_we = 1'b0;
    next_we  = 1'b0;
    wr_addr  = head_idx;
    wr_state = chs_pkg::ST_EMPTY;
    wr_next  = NIL;
    unique case (cmd.wr_sel)
      chs_pkg::WR_NONE: begin
      end
      chs_pkg::WR_CLEAR: begin
        wr_addr  = clr_idx;
        state_we = 1'b1;
        next_we  = 1'b1;
        wr_next  = clr_init;
      end
      chs_pkg::WR_HEAD_INS: begin
        key_we   = 1'b1;
        state_we = 1'b1;
        wr_state = chs_pkg::ST_USED;
      end
      chs_pkg::WR_HEAD_DEL: begin
        state_we = 1'b1;
        wr_state = chs_pkg::ST_DELETED;
      end
      chs_pkg::WR_SPARE_INS: begin
        wr_addr  = cur;
        key_we   = 1'b1;
        state_we = 1'b1;
        wr_state = chs_pkg::ST_USED;
        next_we  = 1'b1;
        wr_next  = head_next;
      end
      chs_pkg::WR_HEAD_LINK: begin
        next_we = 1'b1;
        wr_next = cur;
      end
      chs_pkg::WR_PREV_UNLINK: begin
        wr_addr = prev;
        next_we = 1'b1;
        wr_next = rd_next;
      end
      chs_pkg::WR_CUR_FREE: begin
        wr_addr  = cur;
        state_we = 1'b1;
        next_we  = 1'b1;
        wr_next  = free_head;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      mem_key[wr_addr[AW-1:0]] <= op_key;
    end
    if (state_we) begin
      mem_state[wr_addr[AW-1:0]] <= wr_state;
    end
    if (next_we) begin
      mem_next[wr_addr[AW-1:0]] <= wr_next;
    end
    if (cmd.rd_en) begin
      cur      <= rd_addr;
      rd_key   <= mem_key[rd_addr[AW-1:0]];
      rd_state <= mem_state[rd_addr[AW-1:0]];
      rd_next  <= mem_next[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prev_load) begin
      prev <= cur;
    end
    if (cmd.steps_clr) begin
      steps <= '0;
    end else if (cmd.steps_inc) begin
      steps <= steps + SW'(1);
    end
    if (cmd.cap_head) begin
      head_state <= rd_state;
      head_next  <= rd_next;
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_code;
      unique case (cmd.res_slot)
        chs_pkg::SLOT_NONE: res_slot <= NIL;
        chs_pkg::SLOT_CUR:  res_slot <= cur;
        chs_pkg::SLOT_HEAD: res_slot <= head_idx;
        default:            res_slot <= NIL;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      free_head <= FREE_INIT;
    end else begin
      if (cmd.wr_sel == chs_pkg::WR_CLEAR) begin
        clr_idx <= clr_idx + IDX_W'(1);
      end
      if (cmd.free_pop) begin
        free_head <= rd_next;
      end else if (cmd.free_push) begin
        free_head <= cur;
      end
    end
  end

  assign slot_wide = 32'(res_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      rsp.status <= res_status;
      rsp.slot   <= slot_wide[chs_pkg::SLOT_W-1:0];
    end
  end

  always_comb begin
    sts.func       = op_func;
    sts.mod_done   = mod_done;
    sts.head_ok    = (head_wide < 32'(NODES));
    sts.key_hit    = (rd_state == chs_pkg::ST_USED) && (rd_key == op_key);
    sts.rd_empty   = (rd_state == chs_pkg::ST_EMPTY);
    sts.next_ok    = (rd_next < NIL);
    sts.steps_last = (steps == LAST_STEP);
    sts.free_ok    = (free_head < NIL);
    sts.head_used  = (head_state == chs_pkg::ST_USED);
    sts.out_free   = !rsp_valid || !rsp_stall;
    sts.clr_last   = (clr_idx == LAST_IDX);
  end

endmodule

FILE: rtl/chs_ctrl.sv
// Controller of the chained hash set engine: sequences the clearing pass,
// the hash, chain walks and updates. Depends on chs_pkg.
`timescale 1ns / 1ps

module chs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  chs_pkg::sts_t sts,
  output chs_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HEAD,
    S_FIRST,
    S_WALK,
    S_INS,
    S_LINK,
    S_HLINK,
    S_DFIRST,
    S_DWALK,
    S_DFREE,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   is_insert;
  logic   is_delete;

  assign is_insert = (sts.func == chs_pkg::F_INSERT);
  assign is_delete = (sts.func == chs_pkg::F_DELETE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.rd_sel    = chs_pkg::RD_HEAD;
    cmd.wr_sel    = chs_pkg::WR_NONE;
    cmd.res_code  = chs_pkg::R_ABSENT;
    cmd.res_slot  = chs_pkg::SLOT_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.wr_sel = chs_pkg::WR_CLEAR;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.in_take = 1'b1;
          state_next  = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        if (!sts.head_ok) begin
          cmd.res_load = 1'b1;
          if (is_insert) begin
            cmd.res_code = chs_pkg::R_FULL;
          end else if (is_delete) begin
            cmd.res_code = chs_pkg::R_NOTFOUND;
          end
          state_next = S_DONE;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.steps_clr = 1'b1;
          state_next    = is_delete ? S_DFIRST : S_FIRST;
        end
      end
      S_FIRST, S_WALK: begin
        cmd.cap_head = (state == S_FIRST);
        if (sts.key_hit) begin
          cmd.res_load = 1'b1;
          cmd.res_code = chs_pkg::R_PRESENT;
          cmd.res_slot = chs_pkg::SLOT_CUR;
          state_next   = S_DONE;
        end else if (sts.rd_empty || !sts.next_ok || sts.steps_last) begin
          if (is_insert) begin
            state_next = S_INS;
          end else begin
            cmd.res_load = 1'b1;
            state_next   = S_DONE;
          end
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = chs_pkg::RD_NEXT;
          cmd.steps_inc = 1'b1;
          state_next    = S_WALK;
        end
      end
      S_INS: begin
        if (!sts.head_used) begin
          cmd.wr_sel   = chs_pkg::WR_HEAD_INS;
          cmd.res_load = 1'b1;
          cmd.res_code = chs_pkg::R_INSERTED;
          cmd.res_slot = chs_pkg::SLOT_HEAD;
          state_next   = S_DONE;
        end else if (!sts.free_ok) begin
          cmd.res_load = 1'b1;
          cmd.res_code = chs_pkg::R_FULL;
          state_next   = S_DONE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = chs_pkg::RD_FREE;
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        cmd.wr_sel   = chs_pkg::WR_SPARE_INS;
        cmd.free_pop = 1'b1;
        state_next   = S_HLINK;
      end
      S_HLINK: begin
        cmd.wr_sel   = chs_pkg::WR_HEAD_LINK;
        cmd.res_load = 1'b1;
        cmd.res_code = chs_pkg::R_INSERTED;
        cmd.res_slot = chs_pkg::SLOT_CUR;
        state_next   = S_DONE;
      end
      S_DFIRST: begin
        if (sts.key_hit) begin
          cmd.wr_sel   = chs_pkg::WR_HEAD_DEL;
          cmd.res_load = 1'b1;
          cmd.res_code = chs_pkg::R_DELETED;
          cmd.res_slot = chs_pkg::SLOT_HEAD;
          state_next   = S_DONE;
        end else begin
          cmd.prev_load = 1'b1;
          if (!sts.next_ok) begin
            cmd.res_load = 1'b1;
            cmd.res_code = chs_pkg::R_NOTFOUND;
            state_next   = S_DONE;
          end else begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = chs_pkg::RD_NEXT;
            cmd.steps_clr = 1'b1;
            state_next    = S_DWALK;
          end
        end
      end
      S_DWALK: begin
        if (sts.key_hit) begin
          cmd.wr_sel = chs_pkg::WR_PREV_UNLINK;
          state_next = S_DFREE;
        end else if (sts.steps_last || !sts.next_ok) begin
          cmd.res_load = 1'b1;
          cmd.res_code = chs_pkg::R_NOTFOUND;
          state_next   = S_DONE;
        end else begin
          cmd.prev_load = 1'b1;
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = chs_pkg::RD_NEXT;
          cmd.steps_inc = 1'b1;
        end
      end
      S_DFREE: begin
        cmd.wr_sel    = chs_pkg::WR_CUR_FREE;
        cmd.free_push = 1'b1;
        cmd.res_load  = 1'b1;
        cmd.res_code  = chs_pkg::R_DELETED;
        cmd.res_slot  = chs_pkg::SLOT_CUR;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // The request stall is high in every state but idle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      req_stall <= 1'b1;
    end else begin
      state     <= state_next;
      req_stall <= (state_next != S_IDLE);
    end
  end

endmodule

FILE: rtl/chained_hash_set_engine.sv
// Top level of the chained hash set engine: joins the controller and the
// datapath. Depends on chs_pkg, chs_ctrl and chs_dp.
`timescale 1ns / 1ps

// Usage
// The request channel (req_valid, req_stall, req) carries one operation per
// beat: func selects lookup, insert or delete and key is the 31-bit key. The
// response channel (rsp_valid, rsp_stall, rsp) returns exactly one beat per
// request with a status code and the node slot involved (NODES when none).
// A beat moves on a rising edge where valid is high and stall is low.
// Requests are handled one at a time. Chain nodes are visited one per cycle,
// limited by the single read port of the node memory. An insert into a new
// chain node passes extra states to take a spare node and link it, and a
// delete that unlinks a chain node passes an extra state to free it. A
// bucket count that is not a power of two adds the reciprocal
// multiplication that forms the bucket index.
// After reset the block clears node status and rebuilds the free list in a
// clearing pass, with req_stall high throughout.
// A finished response waits in an output register; while the receiver
// stalls, the block still takes and works on the next request, and only
// holds it back at the point of delivering its response.

module chained_hash_set_engine #(
  parameter int BUCKETS = chs_pkg::BUCKETS_DEF,
  parameter int NODES   = chs_pkg::NODES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  chs_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output chs_pkg::out_t rsp
);

  // Command and status bundles between the sequencer and the datapath.
  chs_pkg::cmd_t cmd;
  chs_pkg::sts_t sts;

  chs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  chs_dp #(
    .BUCKETS (BUCKETS),
    .NODES   (NODES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

endmodule

FILE: tb/chs_set_checker.sv
// Checker for the chained hash set engine: predicts every response beat from
// the accepted requests and compares it field by field. Depends on chs_pkg.
`timescale 1ns / 1ps

module chs_set_checker
  import chs_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int NODES   = NODES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  in_t  req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  out_t rsp,
  output int   fail_count,
  output int   pending
);

  localparam logic [SLOT_W-1:0] NIL = SLOT_W'(NODES);

  // Shadow copy of the node array and the free list.
  logic [KEY_W-1:0]  shadow_key [NODES];
  logic [1:0]        shadow_state [NODES];
  logic [SLOT_W-1:0] shadow_link [NODES];
  logic [SLOT_W-1:0] spare_top;

  out_t expected_rsp [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Bounded chain walk; returns the node holding the key, or NIL.
  function automatic logic [SLOT_W-1:0] chain_find(input logic [SLOT_W-1:0] head,
                                                   input logic [KEY_W-1:0] k);
    logic [SLOT_W-1:0] idx;
    idx = head;
    if (idx >= NIL) return NIL;
    for (int s = 0; s < NODES; s++) begin
      if (shadow_state[idx] == ST_EMPTY) return NIL;
      if (shadow_state[idx] == ST_USED && shadow_key[idx] == k) return idx;
      idx = shadow_link[idx];
      if (idx >= NIL) return NIL;
    end
    return NIL;
  endfunction

  // Applies one operation to the shadow set and returns the response it earns.
  function automatic out_t apply_set_op(input in_t op);
    out_t              res;
    int                hidx;
    logic              head_ok;
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] hit;
    logic [SLOT_W-1:0] spare;
    logic [SLOT_W-1:0] prev;
    logic [SLOT_W-1:0] cur;
    hidx    = int'(op.key % BUCKETS);
    head_ok = hidx < NODES;
    head    = head_ok ? SLOT_W'(hidx) : NIL;
    res.slot = NIL;
    if (op.func == F_INSERT) begin
      hit = chain_find(head, op.key);
      if (hit != NIL) begin
        res.status = R_PRESENT;
        res.slot   = hit;
      end else if (!head_ok) begin
        res.status = R_FULL;
      end else if (shadow_state[head] != ST_USED) begin
        shadow_key[head]   = op.key;
        shadow_state[head] = ST_USED;
        res.status = R_INSERTED;
        res.slot   = head;
      end else if (spare_top >= NIL) begin
        res.status = R_FULL;
      end else begin
        spare = spare_top;
        spare_top           = shadow_link[spare];
        shadow_key[spare]   = op.key;
        shadow_state[spare] = ST_USED;
        shadow_link[spare]  = shadow_link[head];
        shadow_link[head]   = spare;
        res.status = R_INSERTED;
        res.slot   = spare;
      end
    end else if (op.func == F_DELETE) begin
      res.status = R_NOTFOUND;
      if (head_ok) begin
        if (shadow_state[head] == ST_USED && shadow_key[head] == op.key) begin
          shadow_state[head] = ST_DELETED;
          res.status = R_DELETED;
          res.slot   = head;
        end else begin
          prev = head;
          cur  = shadow_link[head];
          for (int s = 0; s < NODES && cur < NIL; s++) begin
            if (shadow_state[cur] == ST_USED && shadow_key[cur] == op.key) begin
              shadow_link[prev]  = shadow_link[cur];
              shadow_state[cur]  = ST_EMPTY;
              shadow_link[cur]   = spare_top;
              spare_top          = cur;
              res.status = R_DELETED;
              res.slot   = cur;
              break;
            end
            prev = cur;
            cur  = shadow_link[cur];
          end
        end
      end
    end else begin
      // Lookup, and the unused code which behaves as one.
      hit = chain_find(head, op.key);
      res.status = (hit != NIL) ? R_PRESENT : R_ABSENT;
      res.slot   = hit;
    end
    return res;
  endfunction

  // Responses are retired before the same edge's request is predicted, so a
  // request taken while an older response leaves never jumps the queue.
  always @(posedge clk) begin : watch
    out_t want;
    if (rst) begin
      for (int i = 0; i < NODES; i++) begin
        shadow_key[i]   = '0;
        shadow_state[i] = ST_EMPTY;
        shadow_link[i]  = (i < BUCKETS) ? NIL : SLOT_W'(i + 1);
      end
      spare_top = (BUCKETS < NODES) ? SLOT_W'(BUCKETS) : NIL;
      expected_rsp.delete();
    end else begin
      if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
        if (expected_rsp.size() == 0) begin
          fail_count++;
          $error("unexpected response beat: status %0d, slot %0d", rsp.status, rsp.slot);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status !== want.status) begin
            fail_count++;
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
          end
          if (rsp.slot !== want.slot) begin
            fail_count++;
            $error("slot: expected %0d, actual %0d", want.slot, rsp.slot);
          end
        end
      end
      if (req_valid && req_stall === 1'b0) expected_rsp.push_back(apply_set_op(req));
    end
    pending = expected_rsp.size();
  end

endmodule

FILE: tb/chained_hash_set_engine_tb.sv
// Testbench top for the chained hash set engine: clock, reset, request
// stimulus, response stalls and the verdict. Depends on chs_pkg,
// chained_hash_set_engine and chs_set_checker.
`timescale 1ns / 1ps

module chained_hash_set_engine_tb;
  import chs_pkg::*;

  localparam int BUCKETS      = BUCKETS_DEF;
  localparam int NODES        = NODES_DEF;
  localparam int RANDOM_ITEMS = 900;
  // Worst case per item is the chain work, the longest receiver stall and the
  // longest sender gap, plus the clearing pass after reset; the limit leaves
  // several times that.
  localparam int CYCLE_LIMIT  = 300000;
  localparam int TAIL_CYCLES  = 60;

  // The fourth func code has no operation of its own; the block treats it as
  // a lookup.
  localparam logic [FUNC_W-1:0] F_SPARE_CODE = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_LONG
  } stall_mode_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  in_t  req;
  logic rsp_valid;
  logic rsp_stall;
  out_t rsp;
  int   fail_count;
  int   pending;
  int   cycle_count;

  chained_hash_set_engine #(
    .BUCKETS(BUCKETS),
    .NODES  (NODES)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  chs_set_checker #(
    .BUCKETS(BUCKETS),
    .NODES  (NODES)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog. A lost response or a hung block ends the run here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver side. The stall pattern switches between modes at random: no
  // stall at all, sparse stalls, a coin toss every cycle, and long stalls
  // with short openings. Since the block keeps working on the next request
  // while its response waits, the long stalls also push back onto the
  // request side.
  initial begin : receiver
    stall_mode_t mode;
    int          span;
    int          phase;
    rsp_stall = 1'b0;
    forever begin
      mode  = stall_mode_t'($urandom_range(0, 3));
      span  = $urandom_range(10, 80);
      phase = 0;
      repeat (span) begin
        @(negedge clk);
        case (mode)
          STALL_NONE:  rsp_stall <= 1'b0;
          STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: rsp_stall <= 1'($urandom_range(0, 1));
          default:     rsp_stall <= (phase % 18) < 15;
        endcase
        phase++;
      end
    end
  end

  // Presents one request beat from the falling edge and holds it until the
  // block takes it. Valid stays high on return so a burst runs back to back.
  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k);
    @(negedge clk);
    req_valid <= 1'b1;
    req.func  <= f;
    req.key   <= k;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
  endtask

  // Sender gap. The payload wanders while valid is low; the block must
  // ignore it.
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      req_valid <= 1'b0;
      req.func  <= FUNC_W'($urandom);
      req.key   <= KEY_W'($urandom);
    end
  endtask

  // Stops sending and waits until every outstanding response has arrived.
  task automatic drain_responses();
    idle_cycles(1);
    while (pending != 0) @(negedge clk);
  endtask

  // Keys mostly land on four crowded buckets with a handful of tags each, so
  // chains grow, the spare nodes run out and deletes find their targets.
  // A share of fully random keys toggles every key bit.
  function automatic logic [KEY_W-1:0] pick_key();
    int bucket;
    int tag;
    if ($urandom_range(0, 9) < 2) return KEY_W'($urandom);
    bucket = ($urandom_range(0, 2) == 0) ? $urandom_range(0, BUCKETS - 1)
                                         : $urandom_range(0, 3);
    tag    = $urandom_range(0, 5);
    return KEY_W'(tag * BUCKETS + bucket);
  endfunction

  // Picks an operation; insert_pct shifts the mix between filling and
  // draining the set.
  function automatic logic [FUNC_W-1:0] pick_func(input int insert_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return F_SPARE_CODE;
    if (r < 4 + insert_pct) return F_INSERT;
    if (r < 4 + insert_pct + (96 - insert_pct) / 2) return F_DELETE;
    return F_LOOKUP;
  endfunction

  initial begin : stimulus
    int   sent;
    int   burst;
    int   insert_pct;
    logic drained_once;

    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. Bucket 0 has four spare nodes to share with everyone,
    // so five keys on it exhaust the free list.
    send_op(F_LOOKUP, 31'd5);            // lookup in an empty set
    send_op(F_SPARE_CODE, 31'd5);        // unused code answers as a lookup
    send_op(F_INSERT, 31'd0);            // smallest key fills head 0
    send_op(F_INSERT, 31'h7fff_ffff);    // largest key fills head 15
    send_op(F_LOOKUP, 31'h7fff_ffff);
    send_op(F_INSERT, 31'd0);            // already present, no change
    send_op(F_INSERT, 31'd16);           // head taken, first spare
    send_op(F_INSERT, 31'd32);           // links right after the head
    send_op(F_INSERT, 31'd48);
    send_op(F_INSERT, 31'd64);           // last spare
    send_op(F_INSERT, 31'd80);           // no spare left, dropped
    send_op(F_LOOKUP, 31'd16);           // found at the end of the chain
    send_op(F_SPARE_CODE, 31'd32);
    send_op(F_DELETE, 31'd32);           // unlinks a chain node
    send_op(F_DELETE, 31'd0);            // marks the head deleted
    send_op(F_DELETE, 31'd0);            // deleted head, chain searched only
    send_op(F_DELETE, 31'd999);          // empty head, nothing to find
    send_op(F_INSERT, 31'd96);           // reuses the deleted head
    send_op(F_INSERT, 31'd112);          // takes the node freed above
    send_op(F_LOOKUP, 31'd80);
    send_op(F_DELETE, 31'h7fff_ffff);
    send_op(F_LOOKUP, 31'h7fff_ffff);    // deleted head, empty chain
    send_op(F_INSERT, 31'h2aaa_aaaa);
    send_op(F_INSERT, 31'h5555_5555);
    send_op(F_DELETE, 31'd16);

    // Let everything settle once before the random part.
    drain_responses();

    // Random part. Bursts of back-to-back beats separated by gaps; the
    // operation mix cycles through fill, balanced and drain every hundred
    // items.
    sent         = 0;
    drained_once = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        case ((sent / 100) % 3)
          0:       insert_pct = 65;
          1:       insert_pct = 40;
          default: insert_pct = 20;
        endcase
        send_op(pick_func(insert_pct), pick_key());
        sent++;
      end
      if (!drained_once && sent >= RANDOM_ITEMS / 2) begin
        drain_responses();
        drained_once = 1'b1;
      end else if ($urandom_range(0, 3) != 0) begin
        idle_cycles($urandom_range(1, 12));
      end
    end

    // Wait for the last responses, then give a stray extra beat time to show.
    drain_responses();
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
